// ===== sv/pgb_pkg.sv =====
// Shared types and constants for the point grid binning block.
package pgb_pkg;

    localparam int COORD_W   = 32;
    localparam int MAX_POINTS = 1024;
    localparam int PT_AW     = $clog2(MAX_POINTS);
    localparam int HELD_W    = PT_AW + 1;
    localparam int GRID_W    = 4;
    localparam int MAX_GRID  = 8;
    localparam int AXIS_W    = $clog2(MAX_GRID);
    localparam int CELLS     = MAX_GRID * MAX_GRID;
    localparam int CELL_W    = $clog2(CELLS);
    localparam int COUNT_W   = 11;
    localparam int QUOT_W    = AXIS_W + 1;
    localparam int NUM_W     = COORD_W + GRID_W;

    localparam logic [GRID_W-1:0]  GRID_RESET = GRID_W'(8);
    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

    // One input beat
    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      last_point;
    } point_t;

    // One result beat
    typedef struct packed {
        logic [CELL_W-1:0]  cell_index;
        logic [COUNT_W-1:0] cell_count;
        logic               last_cell;
        logic               overflowed;
    } cell_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic clear_step;
        logic fetch;
        logic setup;
        logic div_step;
        logic cnt_read;
        logic cnt_write;
        logic emit_step;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clear_last;
        logic div_last;
        logic point_last;
        logic emit_last;
    } status_t;

endpackage

// ===== sv/pgb_axis_div.sv =====
// Per-axis bin index: restoring divide of diff*g by range, one quotient bit per cycle.
module pgb_axis_div (
    input  logic                              clk,
    input  logic                              load,
    input  logic                              step,
    input  logic [pgb_pkg::COORD_W-1:0]       diff,
    input  logic [pgb_pkg::COORD_W-1:0]       span,
    input  logic [pgb_pkg::GRID_W-1:0]        grid,
    output logic [pgb_pkg::AXIS_W-1:0]        idx
);

    logic [pgb_pkg::NUM_W-1:0]  rem_reg;
    logic [pgb_pkg::NUM_W-1:0]  dsr_reg;
    logic [pgb_pkg::QUOT_W-1:0] quot_reg;
    logic                       zero_reg;
    logic [pgb_pkg::GRID_W-1:0] grid_m1;

    // Load numerator and aligned divisor, then shift one bit per step
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg  <= pgb_pkg::NUM_W'(diff) * pgb_pkg::NUM_W'(grid);
            dsr_reg  <= pgb_pkg::NUM_W'(span) << pgb_pkg::AXIS_W;
            quot_reg <= '0;
            zero_reg <= (span == '0);
        end
        else if (step)
        begin
            if (rem_reg >= dsr_reg)
            begin
                rem_reg  <= rem_reg - dsr_reg;
                quot_reg <= {quot_reg[pgb_pkg::QUOT_W-2:0], 1'b1};
            end
            else
            begin
                quot_reg <= {quot_reg[pgb_pkg::QUOT_W-2:0], 1'b0};
            end
            dsr_reg <= dsr_reg >> 1;
        end
    end

    // Clamp to g-1 and force zero on an empty range
    assign grid_m1 = grid - pgb_pkg::GRID_W'(1);

    always_comb
    begin
        if (zero_reg)
            idx = '0;
        else if (pgb_pkg::GRID_W'(quot_reg) >= grid)
            idx = grid_m1[pgb_pkg::AXIS_W-1:0];
        else
            idx = quot_reg[pgb_pkg::AXIS_W-1:0];
    end

endmodule

// ===== sv/pgb_datapath.sv =====
// Datapath: point store, bounding box, axis dividers, cell counters and result register.
module pgb_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pgb_pkg::cmd_t                 cmd,
    output pgb_pkg::status_t              status,
    input  pgb_pkg::point_t               point,
    input  logic                          cfg_valid,
    input  logic [pgb_pkg::GRID_W-1:0]    cfg_data,
    output pgb_pkg::cell_t                result,
    output logic                          cell_valid
);

    localparam int CW = pgb_pkg::COORD_W;

    // Point store and its read register
    logic [2*CW-1:0] store_mem [pgb_pkg::MAX_POINTS];
    logic [2*CW-1:0] store_rd_reg;

    // Cell count memory and its read register
    logic [pgb_pkg::COUNT_W-1:0] count_mem [pgb_pkg::CELLS];
    logic [pgb_pkg::COUNT_W-1:0] count_rd_reg;

    logic [pgb_pkg::HELD_W-1:0]  held_reg;
    logic [pgb_pkg::PT_AW-1:0]   pt_idx_reg;
    logic [CW-1:0]               xmin_reg, xmax_reg, ymin_reg, ymax_reg;
    logic                        drop_reg;
    logic [pgb_pkg::GRID_W-1:0]  grid_reg;
    logic [1:0]                  bit_cnt_reg;
    logic [pgb_pkg::CELL_W-1:0]  cell_cnt_reg;
    logic [pgb_pkg::CELL_W-1:0]  cell_addr_reg;
    logic                        valid_reg;
    logic [pgb_pkg::CELL_W-1:0]  out_idx_reg;
    logic                        out_last_reg;

    logic [CW-1:0]               bx, by;
    logic                        full;
    logic [pgb_pkg::GRID_W-1:0]  grid_eff;
    logic [pgb_pkg::CELL_W:0]    cells;
    logic [pgb_pkg::AXIS_W-1:0]  col, row;
    logic [pgb_pkg::CELL_W:0]    cell_sum;
    logic [pgb_pkg::CELL_W-1:0]  cell_sel;
    logic [pgb_pkg::CELL_W-1:0]  rd_addr;
    logic [pgb_pkg::COUNT_W-1:0] count_inc;

    // Offset-binary form of the incoming coordinates
    assign bx   = {~point.point_x[CW-1], point.point_x[CW-2:0]};
    assign by   = {~point.point_y[CW-1], point.point_y[CW-2:0]};
    assign full = (held_reg == pgb_pkg::HELD_W'(pgb_pkg::MAX_POINTS));

    // Effective grid size: zero acts as one, large values saturate
    always_comb
    begin
        if (grid_reg == '0)
            grid_eff = pgb_pkg::GRID_W'(1);
        else if (grid_reg > pgb_pkg::GRID_W'(pgb_pkg::MAX_GRID))
            grid_eff = pgb_pkg::GRID_W'(pgb_pkg::MAX_GRID);
        else
            grid_eff = grid_reg;
    end

    assign cells = (pgb_pkg::CELL_W+1)'(grid_eff) * (pgb_pkg::CELL_W+1)'(grid_eff);

    // Hold the grid size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            grid_reg <= pgb_pkg::GRID_RESET;
        else if (cfg_valid)
            grid_reg <= cfg_data;
    end

    // Store accepted points
    always_ff @(posedge clk)
    begin
        if (cmd.accept && !full)
            store_mem[held_reg[pgb_pkg::PT_AW-1:0]] <= {bx, by};
        if (cmd.fetch)
            store_rd_reg <= store_mem[pt_idx_reg];
    end

    // Track the set: fill level, bounding box, drop flag, counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg     <= '0;
            pt_idx_reg   <= '0;
            xmin_reg     <= '1;
            ymin_reg     <= '1;
            xmax_reg     <= '0;
            ymax_reg     <= '0;
            drop_reg     <= 1'b0;
            bit_cnt_reg  <= '0;
            cell_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                if (full)
                begin
                    drop_reg <= 1'b1;
                end
                else
                begin
                    held_reg <= held_reg + pgb_pkg::HELD_W'(1);
                    if (bx < xmin_reg) xmin_reg <= bx;
                    if (bx > xmax_reg) xmax_reg <= bx;
                    if (by < ymin_reg) ymin_reg <= by;
                    if (by > ymax_reg) ymax_reg <= by;
                end
            end
            if (cmd.setup)
                bit_cnt_reg <= '0;
            else if (cmd.div_step)
                bit_cnt_reg <= bit_cnt_reg + 2'd1;
            if (cmd.cnt_write)
                pt_idx_reg <= pt_idx_reg + pgb_pkg::PT_AW'(1);
            if (cmd.clear_step || cmd.emit_step)
                cell_cnt_reg <= cell_cnt_reg + pgb_pkg::CELL_W'(1);
            if (cmd.finish)
            begin
                held_reg     <= '0;
                pt_idx_reg   <= '0;
                xmin_reg     <= '1;
                ymin_reg     <= '1;
                xmax_reg     <= '0;
                ymax_reg     <= '0;
                drop_reg     <= 1'b0;
                cell_cnt_reg <= '0;
            end
        end
    end

    // Column and row dividers
    pgb_axis_div u_div_x (
        .clk  (clk),
        .load (cmd.setup),
        .step (cmd.div_step),
        .diff (store_rd_reg[2*CW-1:CW] - xmin_reg),
        .span (xmax_reg - xmin_reg),
        .grid (grid_eff),
        .idx  (col)
    );

    pgb_axis_div u_div_y (
        .clk  (clk),
        .load (cmd.setup),
        .step (cmd.div_step),
        .diff (store_rd_reg[CW-1:0] - ymin_reg),
        .span (ymax_reg - ymin_reg),
        .grid (grid_eff),
        .idx  (row)
    );

    // Cell number: column times g plus row
    assign cell_sum = (pgb_pkg::CELL_W+1)'(col) * (pgb_pkg::CELL_W+1)'(grid_eff)
                    + (pgb_pkg::CELL_W+1)'(row);
    assign cell_sel = cell_sum[pgb_pkg::CELL_W-1:0];

    assign rd_addr   = cmd.cnt_read ? cell_sel : cell_cnt_reg;
    assign count_inc = (count_rd_reg == pgb_pkg::COUNT_MAX) ? count_rd_reg
                                                            : count_rd_reg + pgb_pkg::COUNT_W'(1);

    // Count memory: clear sweep, read-modify-write, emit reads
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
            count_mem[cell_cnt_reg] <= '0;
        else if (cmd.cnt_write)
            count_mem[cell_addr_reg] <= count_inc;
        if (cmd.cnt_read || cmd.emit_step)
            count_rd_reg <= count_mem[rd_addr];
        if (cmd.cnt_read)
            cell_addr_reg <= cell_sel;
        if (cmd.emit_step)
        begin
            out_idx_reg  <= cell_cnt_reg;
            out_last_reg <= status.emit_last;
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= cmd.emit_step;
    end

    assign cell_valid         = valid_reg;
    assign result.cell_index  = out_idx_reg;
    assign result.cell_count  = count_rd_reg;
    assign result.last_cell   = out_last_reg;
    assign result.overflowed  = drop_reg;

    // Status back to the controller
    assign status.clear_last = (cell_cnt_reg == pgb_pkg::CELL_W'(pgb_pkg::CELLS - 1));
    assign status.div_last   = (bit_cnt_reg == 2'd3);
    assign status.point_last = ({1'b0, pt_idx_reg} == held_reg - pgb_pkg::HELD_W'(1));
    assign status.emit_last  = ({1'b0, cell_cnt_reg} == cells - (pgb_pkg::CELL_W+1)'(1));

endmodule

// ===== sv/pgb_ctrl.sv =====
// Controller state machine sequencing load, clear, binning and emit phases.
module pgb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              last_point,
    input  pgb_pkg::status_t  status,
    output pgb_pkg::cmd_t     cmd,
    output logic              busy
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_CLEAR  = 9'b000000010,
        S_FETCH  = 9'b000000100,
        S_SETUP  = 9'b000001000,
        S_DIV    = 9'b000010000,
        S_CNT_RD = 9'b000100000,
        S_CNT_WR = 9'b001000000,
        S_EMIT   = 9'b010000000,
        S_FLUSH  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Advance the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    if (last_point)
                        state_next = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                    state_next = S_FETCH;
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = S_CNT_RD;
            end
            S_CNT_RD:
            begin
                cmd.cnt_read = 1'b1;
                state_next   = S_CNT_WR;
            end
            S_CNT_WR:
            begin
                cmd.cnt_write = 1'b1;
                state_next    = status.point_last ? S_EMIT : S_FETCH;
            end
            S_EMIT:
            begin
                cmd.emit_step = 1'b1;
                if (status.emit_last)
                    state_next = S_FLUSH;
            end
            S_FLUSH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== sv/point_grid_binning_top.sv =====
// Top level of the point grid binning block.
//
// Input: a point beat (point_x, point_y, last_point) is taken at a clock edge
// with start high and busy low. Non-last points give no result; up to 1024
// points are stored, later ones are dropped and flagged. The last point starts
// a pass: a sweep clears all 64 cell counters, then each stored point goes
// through store read, divider setup, four quotient-bit steps shared by both
// axes, counter read and write; then one result beat per cell is emitted,
// g*g beats for grid size g, and a final flush state closes the set. busy
// stays high for the pass.
// Output: result is valid for exactly one cycle while cell_valid is high; the
// receiver cannot stall, so every beat must be taken as it appears.
// Configuration: grid_size is written over cfg_valid/cfg_ready/cfg_data; the user must write it
// only while the block is idle, which the block itself does not enforce; cfg_ready is always high.
// Reset: clears the set, the bounding box and the drop flag, and sets the
// grid size to 8. The point store needs no initialization.
module point_grid_binning_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  pgb_pkg::point_t               point,
    output pgb_pkg::cell_t                result,
    output logic                          cell_valid,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pgb_pkg::GRID_W-1:0]    cfg_data
);

    pgb_pkg::cmd_t    cmd;
    pgb_pkg::status_t status;

    // Accept configuration beats at any time
    assign cfg_ready = 1'b1;

    pgb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .last_point (point.last_point),
        .status     (status),
        .cmd        (cmd),
        .busy       (busy)
    );

    pgb_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .point      (point),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .result     (result),
        .cell_valid (cell_valid)
    );

endmodule

// ===== sim/tb_point_grid_binning_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the point grid binning block with a bin count predictor.
module tb_point_grid_binning_top;
    import pgb_pkg::*;

    localparam int QUIET_LIMIT = 40000;
    localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

    // Tracks the point set and bounding box; predicts the cell counts of each pass
    class bin_count_predictor;
        logic [COORD_W-1:0] x_held [MAX_POINTS];
        logic [COORD_W-1:0] y_held [MAX_POINTS];
        int unsigned        n_held;
        logic [COORD_W-1:0] x_lo, x_hi, y_lo, y_hi;
        bit                 dropped;
        logic [GRID_W-1:0]  grid;
        cell_t              expected_cells [$];
        int                 errors;

        function new();
            grid = GRID_RESET;
            errors = 0;
            restart_set();
        endfunction

        function void restart_set();
            n_held = 0;
            x_lo = '1;
            y_lo = '1;
            x_hi = '0;
            y_hi = '0;
            dropped = 1'b0;
        endfunction

        // floor(diff * g / range), clamped to g-1; a zero range maps to 0
        function int axis_slot(logic [COORD_W-1:0] diff, logic [COORD_W-1:0] range, int g);
            longint unsigned scaled;
            int slot;
            slot = 0;
            if (range == 0)
                return 0;
            scaled = 64'(diff) * 64'(g);
            for (int k = 1; k < g; k++)
            begin
                if (scaled >= 64'(range) * 64'(k))
                    slot = k;
            end
            return slot;
        endfunction

        // Take one accepted point beat; on the last point queue the whole pass
        function void take_point(point_t p);
            logic [COORD_W-1:0] bx, by;
            int g, col, row, c;
            int counts [CELLS];
            cell_t e;
            // offset-binary keeps unsigned compares and differences exact
            bx = p.point_x ^ COORD_MIN;
            by = p.point_y ^ COORD_MIN;
            if (n_held < MAX_POINTS)
            begin
                x_held[n_held] = bx;
                y_held[n_held] = by;
                n_held++;
                if (bx < x_lo) x_lo = bx;
                if (bx > x_hi) x_hi = bx;
                if (by < y_lo) y_lo = by;
                if (by > y_hi) y_hi = by;
            end
            else
                dropped = 1'b1;
            if (!p.last_point)
                return;

            if (grid == 0)
                g = 1;
            else if (grid > MAX_GRID)
                g = MAX_GRID;
            else
                g = int'(grid);

            foreach (counts[i])
                counts[i] = 0;
            for (int i = 0; i < n_held; i++)
            begin
                col = axis_slot(x_held[i] - x_lo, x_hi - x_lo, g);
                row = axis_slot(y_held[i] - y_lo, y_hi - y_lo, g);
                c = col * g + row;
                if (counts[c] < COUNT_MAX)
                    counts[c]++;
            end

            for (int i = 0; i < g * g; i++)
            begin
                e.cell_index = CELL_W'(i);
                e.cell_count = COUNT_W'(counts[i]);
                e.last_cell  = (i == g * g - 1);
                e.overflowed = dropped;
                expected_cells.push_back(e);
            end
            restart_set();
        endfunction

        // Compare one result beat with the oldest expected cell
        function void check_cell(cell_t got);
            cell_t want;
            if (expected_cells.size() == 0)
            begin
                $error("cell beat with nothing expected: cell_index %0d", got.cell_index);
                errors++;
                return;
            end
            want = expected_cells.pop_front();
            if (got.cell_index !== want.cell_index)
            begin
                $error("cell_index: expected %0d, got %0d", want.cell_index, got.cell_index);
                errors++;
            end
            if (got.cell_count !== want.cell_count)
            begin
                $error("cell_count: expected %0d, got %0d", want.cell_count, got.cell_count);
                errors++;
            end
            if (got.last_cell !== want.last_cell)
            begin
                $error("last_cell: expected %0d, got %0d", want.last_cell, got.last_cell);
                errors++;
            end
            if (got.overflowed !== want.overflowed)
            begin
                $error("overflowed: expected %0d, got %0d", want.overflowed, got.overflowed);
                errors++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    point_t            point = '0;
    cell_t             result;
    logic              cell_valid;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [GRID_W-1:0] cfg_data = '0;

    bit idle_on = 1'b1;
    int idle_odds = 30;
    int quiet_cycles = 0;
    int rand_items = 0;
    bin_count_predictor bin_counts = new();

    point_grid_binning_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .point      (point),
        .result     (result),
        .cell_valid (cell_valid),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always #4 clk = ~clk;

    // Check every result beat as it appears
    always @(posedge clk)
    begin
        if (rst_n && cell_valid)
            bin_counts.check_cell(result);
    end

    // Stop the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n && ((start && !busy) || cell_valid || (cfg_valid && cfg_ready)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic point_t mk_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                        bit last);
        point_t p;
        p.point_x = x;
        p.point_y = y;
        p.last_point = last;
        return p;
    endfunction

    function automatic logic [COORD_W-1:0] pick_extreme();
        case ($urandom_range(0, 5))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return '0;
            3: return '1;
            4: return 1;
            default: return $urandom;
        endcase
    endfunction

    // Present one point beat, optionally after an idle burst, and hold until taken
    task automatic send_point(point_t p);
        if (idle_on && $urandom_range(0, 99) < idle_odds)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        start <= 1'b1;
        point <= p;
        do @(posedge clk); while (busy);
        bin_counts.take_point(p);
    endtask

    // Drop start and wait until every expected cell has come out
    task automatic wait_drained();
        start <= 1'b0;
        while (bin_counts.expected_cells.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_grid(logic [GRID_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        bin_counts.grid = v;
    endtask

    // Send one point set of n points in a randomly chosen coordinate pattern
    task automatic random_set(int n);
        int style;
        logic [COORD_W-1:0] bx, by, step_x, step_y;
        point_t p;
        style = $urandom_range(0, 4);
        bx = $urandom;
        by = $urandom;
        step_x = $urandom_range(1, 1 << 20);
        step_y = $urandom_range(1, 1 << 20);
        for (int i = 0; i < n; i++)
        begin
            case (style)
                0:
                begin
                    p.point_x = $urandom;
                    p.point_y = $urandom;
                end
                1:
                begin
                    p.point_x = bx + $urandom_range(0, 15);
                    p.point_y = by + $urandom_range(0, 15);
                end
                2:
                begin
                    p.point_x = bx;
                    p.point_y = $urandom;
                end
                3:
                begin
                    p.point_x = pick_extreme();
                    p.point_y = pick_extreme();
                end
                default:
                begin
                    // points on exact cell boundaries
                    p.point_x = bx + step_x * $urandom_range(0, 8);
                    p.point_y = by + step_y * $urandom_range(0, 8);
                end
            endcase
            p.last_point = (i == n - 1);
            send_point(p);
        end
    endtask

    initial
    begin
        logic [GRID_W-1:0] grid_plan [6];
        int phase;
        int n;
        grid_plan = '{4'd1, 4'd0, 4'd15, 4'd8, 4'd2, 4'd5};
        phase = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single point: zero range on both axes
        send_point(mk_point(0, 0, 1'b1));
        // Coordinate extremes
        send_point(mk_point(COORD_MIN, COORD_MIN, 1'b0));
        send_point(mk_point(COORD_MAX, COORD_MAX, 1'b0));
        send_point(mk_point(COORD_MIN, COORD_MAX, 1'b0));
        send_point(mk_point(COORD_MAX, COORD_MIN, 1'b0));
        send_point(mk_point(0, 0, 1'b0));
        send_point(mk_point(-1, 1, 1'b1));
        // Zero range on x only
        send_point(mk_point(5, -3, 1'b0));
        send_point(mk_point(5, 7, 1'b0));
        send_point(mk_point(5, 100, 1'b1));
        // Exact boundaries, top edge clamped into the last column
        for (int k = 0; k <= 8; k++)
            send_point(mk_point(k, 8 - k, k == 8));

        // Overflow the store; the last point itself is dropped
        wait_drained();
        write_grid(4'd3);
        random_set(MAX_POINTS + 2);

        // Random sets over several grid sizes, no idling at the end
        while (rand_items < 130)
        begin
            wait_drained();
            write_grid(phase < 6 ? grid_plan[phase] : GRID_W'($urandom_range(0, 15)));
            phase++;
            idle_on = (rand_items < 100);
            idle_odds = $urandom_range(0, 50);
            repeat ($urandom_range(1, 3))
            begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
                random_set(n);
                rand_items += n;
            end
        end

        wait_drained();
        repeat (16) @(posedge clk);
        if (bin_counts.errors == 0 && bin_counts.expected_cells.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
